@@ sv/rta_pkg.sv @@
// ----------------------------------------------------------------------------
// rta_pkg: shared types and constants for the region table allocator
// Widths, status and operation codes, and the layout of one table entry.
// ----------------------------------------------------------------------------
package rta_pkg;

    localparam int STORE_MAX_BYTES = 65536;
    localparam int MAX_ENTRIES     = 64;
    localparam int OWNER_BITS      = 16;

    localparam int LEN_BITS   = 17;
    localparam int ADDR_BITS  = 16;
    localparam int SPAN_BITS  = 17;
    localparam int NEED_BITS  = LEN_BITS + 1;
    localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int CFG_BITS   = 17;
    localparam int STAT_BITS  = 3;
    localparam int OP_BITS    = 2;

    localparam logic [OP_BITS-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CHECK = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NONE  = 2'd3;

    localparam logic [STAT_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_BAD_SIZE   = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_NO_MEMORY  = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_INVALID    = 3'd4;
    localparam logic [STAT_BITS-1:0] ST_TOO_SMALL  = 3'd5;

    localparam logic CFG_STORE_BYTES   = 1'b0;
    localparam logic CFG_BLOCK_GRANULE = 1'b1;

    typedef struct packed {
        logic [OWNER_BITS-1:0] owner;
        logic [SPAN_BITS-1:0]  span;
        logic [ADDR_BITS-1:0]  start;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

endpackage

@@ sv/region_table_allocator.sv @@
// ----------------------------------------------------------------------------
// region_table_allocator: bump allocator with best-fit reuse of free regions
// Sequencer over a 64-entry region table held in RAM.
// ----------------------------------------------------------------------------
// One word at a time. Free and check read the table until the holding region
// is found (one entry per cycle from the table RAM). An allocation rounds the
// length up to the granule with the 17-step serial remainder unit, then takes
// the bump path, or scans the table for the best fit once the store is full.
// Bad size and unknown operations go straight to the result. No clearing
// pass: only entries below the entry count are read.
module region_table_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rta_pkg::OP_BITS-1:0]         op,
    input  logic [rta_pkg::LEN_BITS-1:0]        length,
    input  logic [rta_pkg::ADDR_BITS-1:0]       address,
    input  logic [rta_pkg::OWNER_BITS-1:0]      requester,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rta_pkg::STAT_BITS-1:0]       status,
    output logic [rta_pkg::ADDR_BITS-1:0]       granted_offset,
    output logic [rta_pkg::IDX_BITS-1:0]        region_index,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [rta_pkg::CFG_BITS-1:0]        cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_NEED,
        S_ALLOC,
        S_SCAN,
        S_RESOLVE,
        S_FINISH
    } state_t;

    localparam logic [rta_pkg::NEED_BITS-1:0] CAP_MAX =
        rta_pkg::NEED_BITS'(rta_pkg::STORE_MAX_BYTES);

    state_t                             state_reg, state_next;
    logic [rta_pkg::CFG_BITS-1:0]       store_reg, store_next;
    logic [rta_pkg::CFG_BITS-1:0]       gran_reg, gran_next;
    logic [rta_pkg::OP_BITS-1:0]        op_reg, op_next;
    logic [rta_pkg::LEN_BITS-1:0]       len_reg, len_next;
    logic [rta_pkg::ADDR_BITS-1:0]      addr_reg, addr_next;
    logic [rta_pkg::OWNER_BITS-1:0]     who_reg, who_next;
    logic [rta_pkg::LEN_BITS-1:0]       g_reg, g_next;
    logic [rta_pkg::NEED_BITS-1:0]      need_reg, need_next;
    logic [rta_pkg::SPAN_BITS-1:0]      bho_reg, bho_next;
    logic [rta_pkg::CNT_BITS-1:0]       count_reg, count_next;
    logic                               best_mode_reg, best_mode_next;
    logic [rta_pkg::CNT_BITS-1:0]       rd_idx_reg, rd_idx_next;
    logic                               ev_valid_reg, ev_valid_next;
    logic [rta_pkg::IDX_BITS-1:0]       ev_idx_reg, ev_idx_next;
    logic                               have_reg, have_next;
    rta_pkg::entry_t                    hit_reg, hit_next;
    logic [rta_pkg::IDX_BITS-1:0]       hit_idx_reg, hit_idx_next;
    logic [rta_pkg::STAT_BITS-1:0]      res_stat_reg, res_stat_next;
    logic [rta_pkg::ADDR_BITS-1:0]      res_off_reg, res_off_next;
    logic [rta_pkg::IDX_BITS-1:0]       res_idx_reg, res_idx_next;
    logic                               out_valid_reg, out_valid_next;
    logic [rta_pkg::STAT_BITS-1:0]      out_stat_reg, out_stat_next;
    logic [rta_pkg::ADDR_BITS-1:0]      out_off_reg, out_off_next;
    logic [rta_pkg::IDX_BITS-1:0]       out_idx_reg, out_idx_next;

    logic                               div_start;
    logic                               div_done;
    logic [rta_pkg::LEN_BITS-1:0]       div_rem;

    logic                               ram_we;
    logic [rta_pkg::IDX_BITS-1:0]       ram_waddr;
    rta_pkg::entry_t                    ram_wdata;
    logic [rta_pkg::IDX_BITS-1:0]       ram_raddr;
    logic [rta_pkg::ENTRY_BITS-1:0]     ram_rdata;
    rta_pkg::entry_t                    ev_entry;

    logic                               in_fire;
    logic [rta_pkg::NEED_BITS-1:0]      cap;
    logic [rta_pkg::NEED_BITS:0]        bump_end;
    logic [rta_pkg::NEED_BITS-1:0]      ev_end;
    logic [rta_pkg::ADDR_BITS-1:0]      rel;
    logic [rta_pkg::NEED_BITS-1:0]      rel_end;

    rta_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (len_reg),
        .divisor   (g_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    rta_ram #(
        .WIDTH (rta_pkg::ENTRY_BITS),
        .DEPTH (rta_pkg::MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ev_entry  = rta_pkg::entry_t'(ram_rdata);
    assign in_fire   = in_valid && in_ready;
    assign cap       = ({1'b0, store_reg} > CAP_MAX) ? CAP_MAX : {1'b0, store_reg};
    assign bump_end  = {2'b00, bho_reg} + {1'b0, need_reg};
    assign ev_end    = {2'b00, ev_entry.start} + {1'b0, ev_entry.span};
    assign rel       = (addr_reg >= hit_reg.start) ? (addr_reg - hit_reg.start) : '0;
    assign rel_end   = {2'b00, rel} + {1'b0, len_reg};

    always_comb
    begin
        state_next     = state_reg;
        store_next     = store_reg;
        gran_next      = gran_reg;
        op_next        = op_reg;
        len_next       = len_reg;
        addr_next      = addr_reg;
        who_next       = who_reg;
        g_next         = g_reg;
        need_next      = need_reg;
        bho_next       = bho_reg;
        count_next     = count_reg;
        best_mode_next = best_mode_reg;
        rd_idx_next    = rd_idx_reg;
        ev_valid_next  = 1'b0;
        ev_idx_next    = ev_idx_reg;
        have_next      = have_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        res_stat_next  = res_stat_reg;
        res_off_next   = res_off_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_off_next   = out_off_reg;
        out_idx_next   = out_idx_reg;
        div_start      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = hit_idx_reg;
        ram_wdata      = hit_reg;
        ram_raddr      = rd_idx_reg[rta_pkg::IDX_BITS-1:0];

        if (cfg_valid)
        begin
            if (cfg_index == rta_pkg::CFG_STORE_BYTES)
            begin
                store_next = cfg_data;
            end
            else
            begin
                gran_next = cfg_data;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next       = op;
                    len_next      = length;
                    addr_next     = address;
                    who_next      = requester;
                    g_next        = (gran_reg == '0) ? rta_pkg::LEN_BITS'(1) : gran_reg;
                    res_off_next  = '0;
                    res_idx_next  = '0;
                    rd_idx_next   = '0;
                    have_next     = 1'b0;
                    best_mode_next = 1'b0;
                    if (op == rta_pkg::OP_NONE)
                    begin
                        res_stat_next = rta_pkg::ST_INVALID;
                        state_next    = S_FINISH;
                    end
                    else if (op != rta_pkg::OP_FREE && length == '0)
                    begin
                        res_stat_next = rta_pkg::ST_BAD_SIZE;
                        state_next    = S_FINISH;
                    end
                    else if (op == rta_pkg::OP_ALLOC)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_DIV:
            begin
                div_start  = (rd_idx_reg == '0) && !have_reg;
                have_next  = 1'b1;
                if (div_done)
                begin
                    have_next  = 1'b0;
                    state_next = S_NEED;
                end
            end

            S_NEED:
            begin
                if (div_rem == '0)
                begin
                    need_next = {1'b0, len_reg};
                end
                else
                begin
                    need_next = {1'b0, len_reg} + {1'b0, g_reg} - {1'b0, div_rem};
                end
                state_next = S_ALLOC;
            end

            S_ALLOC:
            begin
                if (bump_end > {1'b0, cap})
                begin
                    best_mode_next = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (count_reg >= rta_pkg::CNT_BITS'(rta_pkg::MAX_ENTRIES))
                begin
                    res_stat_next = rta_pkg::ST_TABLE_FULL;
                    state_next    = S_FINISH;
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = count_reg[rta_pkg::IDX_BITS-1:0];
                    ram_wdata.owner = who_reg;
                    ram_wdata.span  = need_reg[rta_pkg::SPAN_BITS-1:0];
                    ram_wdata.start = bho_reg[rta_pkg::ADDR_BITS-1:0];
                    bho_next        = rta_pkg::SPAN_BITS'(bump_end);
                    count_next      = count_reg + 1'b1;
                    res_stat_next   = rta_pkg::ST_OK;
                    res_off_next    = bho_reg[rta_pkg::ADDR_BITS-1:0];
                    res_idx_next    = count_reg[rta_pkg::IDX_BITS-1:0];
                    state_next      = S_FINISH;
                end
            end

            S_SCAN:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    ev_valid_next = 1'b1;
                    ev_idx_next   = rd_idx_reg[rta_pkg::IDX_BITS-1:0];
                end
                if (ev_valid_reg)
                begin
                    if (best_mode_reg)
                    begin
                        if (ev_entry.owner == '0 && {1'b0, ev_entry.span} >= need_reg
                            && (!have_reg || ev_entry.span < hit_reg.span))
                        begin
                            have_next    = 1'b1;
                            hit_next     = ev_entry;
                            hit_idx_next = ev_idx_reg;
                        end
                    end
                    else if ({2'b00, addr_reg} < ev_end)
                    begin
                        hit_next      = ev_entry;
                        hit_idx_next  = ev_idx_reg;
                        ev_valid_next = 1'b0;
                        state_next    = S_RESOLVE;
                    end
                end
                else if (rd_idx_reg >= count_reg)
                begin
                    state_next = S_FINISH;
                    if (!best_mode_reg)
                    begin
                        res_stat_next = rta_pkg::ST_INVALID;
                    end
                    else if (!have_reg)
                    begin
                        res_stat_next = rta_pkg::ST_NO_MEMORY;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_wdata.owner = who_reg;
                        res_stat_next   = rta_pkg::ST_OK;
                        res_off_next    = hit_reg.start;
                        res_idx_next    = hit_idx_reg;
                    end
                end
            end

            S_RESOLVE:
            begin
                state_next = S_FINISH;
                if (hit_reg.owner != who_reg)
                begin
                    res_stat_next = rta_pkg::ST_INVALID;
                end
                else if (op_reg == rta_pkg::OP_FREE)
                begin
                    ram_we          = 1'b1;
                    ram_wdata.owner = '0;
                    res_stat_next   = rta_pkg::ST_OK;
                    res_idx_next    = hit_idx_reg;
                end
                else
                begin
                    res_idx_next  = hit_idx_reg;
                    res_stat_next = (rel_end > {1'b0, hit_reg.span}) ?
                                    rta_pkg::ST_TOO_SMALL : rta_pkg::ST_OK;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_off_next   = res_off_reg;
                    out_idx_next   = res_idx_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            store_reg     <= rta_pkg::CFG_BITS'(rta_pkg::STORE_MAX_BYTES);
            gran_reg      <= rta_pkg::CFG_BITS'(8);
            op_reg        <= rta_pkg::OP_ALLOC;
            len_reg       <= '0;
            addr_reg      <= '0;
            who_reg       <= '0;
            g_reg         <= '0;
            need_reg      <= '0;
            bho_reg       <= '0;
            count_reg     <= '0;
            best_mode_reg <= 1'b0;
            rd_idx_reg    <= '0;
            ev_valid_reg  <= 1'b0;
            ev_idx_reg    <= '0;
            have_reg      <= 1'b0;
            hit_reg       <= '0;
            hit_idx_reg   <= '0;
            res_stat_reg  <= rta_pkg::ST_OK;
            res_off_reg   <= '0;
            res_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_stat_reg  <= rta_pkg::ST_OK;
            out_off_reg   <= '0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            store_reg     <= store_next;
            gran_reg      <= gran_next;
            op_reg        <= op_next;
            len_reg       <= len_next;
            addr_reg      <= addr_next;
            who_reg       <= who_next;
            g_reg         <= g_next;
            need_reg      <= need_next;
            bho_reg       <= bho_next;
            count_reg     <= count_next;
            best_mode_reg <= best_mode_next;
            rd_idx_reg    <= rd_idx_next;
            ev_valid_reg  <= ev_valid_next;
            ev_idx_reg    <= ev_idx_next;
            have_reg      <= have_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            res_stat_reg  <= res_stat_next;
            res_off_reg   <= res_off_next;
            res_idx_reg   <= res_idx_next;
            out_valid_reg <= out_valid_next;
            out_stat_reg  <= out_stat_next;
            out_off_reg   <= out_off_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign status         = out_stat_reg;
    assign granted_offset = out_off_reg;
    assign region_index   = out_idx_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rta_pkg::CNT_BITS'(rta_pkg::MAX_ENTRIES))
        else $error("entry count past table depth");

    a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, bho_reg} <= CAP_MAX)
        else $error("bump pointer past store");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("new word taken while busy");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count moved by more than one");

endmodule

@@ sv/rta_ram.sv @@
// ----------------------------------------------------------------------------
// rta_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/rta_divider.sv @@
// ----------------------------------------------------------------------------
// rta_divider: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module rta_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rta_pkg::LEN_BITS-1:0] dividend,
    input  logic [rta_pkg::LEN_BITS-1:0] divisor,
    output logic                         done,
    output logic [rta_pkg::LEN_BITS-1:0] remainder
);

    localparam int CNT_W = $clog2(rta_pkg::LEN_BITS + 1);

    logic [rta_pkg::LEN_BITS-1:0] rem_reg, rem_next;
    logic [rta_pkg::LEN_BITS-1:0] dvd_reg, dvd_next;
    logic [rta_pkg::LEN_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    logic [rta_pkg::LEN_BITS:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[rta_pkg::LEN_BITS-1]};
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(rta_pkg::LEN_BITS);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = rta_pkg::LEN_BITS'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = rta_pkg::LEN_BITS'(trial);
            end
            dvd_next  = {dvd_reg[rta_pkg::LEN_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
